// File: rtl/core/rii_pkg.sv
// shared constants, silicon index table and helper functions for the index interpolator
package rii_pkg;

  localparam int ROM_POINTS        = 33;
  localparam int WL_W              = 16;
  localparam int OUT_W             = 27;
  // widest table segment (12400 - 8266) fits in this many bits
  localparam int SEG_W             = 13;
  localparam int TABLE_ENTRIES_DEF = 33;
  localparam int FRACTION_BITS_DEF = 24;

  localparam logic [63:0] DEC_SCALE = 64'd10000000;
  localparam logic [63:0] OUT_MAX   = (64'd1 << OUT_W) - 64'd1;

  // wavelength in 0.1 nm
  localparam logic [WL_W-1:0] ROM_WL [ROM_POINTS] = '{
    16'd1240, 16'd1305, 16'd1378, 16'd1459, 16'd1550, 16'd1653, 16'd1771,
    16'd1907, 16'd2066, 16'd2254, 16'd2480, 16'd2755, 16'd3100, 16'd3306,
    16'd3542, 16'd3815, 16'd4133, 16'd4275, 16'd4428, 16'd4592, 16'd4769,
    16'd4959, 16'd5166, 16'd5391, 16'd5636, 16'd5904, 16'd6199, 16'd6526,
    16'd6888, 16'd7293, 16'd7749, 16'd8266, 16'd12400
  };

  // real part in units of 1e-7
  localparam logic [31:0] ROM_RE [ROM_POINTS] = '{
    32'd3060000,  32'd3320000,  32'd3670000,  32'd4140000,  32'd4780000,
    32'd5630000,  32'd6820000,  32'd8470000,  32'd11100000, 32'd13400000,
    32'd15700000, 32'd24510000, 32'd50100000, 32'd51050000, 32'd56100000,
    32'd63890000, 32'd52220000, 32'd49610000, 32'd47530000, 32'd45830000,
    32'd44420000, 32'd43200000, 32'd42150000, 32'd41230000, 32'd40420000,
    32'd39690000, 32'd39060000, 32'd38470000, 32'd37960000, 32'd37520000,
    32'd37140000, 32'd36730000, 32'd35163000
  };

  // extinction coefficient in units of 1e-7
  localparam logic [31:0] ROM_IM [ROM_POINTS] = '{
    32'd13800000, 32'd15100000, 32'd16600000, 32'd18200000, 32'd20000000,
    32'd22100000, 32'd24500000, 32'd27300000, 32'd30500000, 32'd33020000,
    32'd35650000, 32'd50820000, 32'd36500000, 32'd31110000, 32'd30140000,
    32'd8800000,  32'd2690000,  32'd2030000,  32'd1630000,  32'd1300000,
    32'd900000,   32'd730000,   32'd600000,   32'd480000,   32'd320000,
    32'd300000,   32'd220000,   32'd160000,   32'd130000,   32'd100000,
    32'd80000,    32'd50000,    32'd15
  };

  // number of table points in use, held between two and the points that exist
  function automatic int used_points(int entries);
    int n;
    n = entries;
    if (n > ROM_POINTS) n = ROM_POINTS;
    if (n < 2) n = 2;
    return n;
  endfunction

  // decimal table value to fixed point, rounded to nearest
  function automatic logic [63:0] to_fixed(logic [31:0] v, int fb);
    int          s;
    logic [63:0] p;
    s = fb;
    if (s > 32) s = 32;
    if (s < 0) s = 0;
    p = {32'd0, v} << s;
    return (p + DEC_SCALE / 64'd2) / DEC_SCALE;
  endfunction

endpackage

// File: rtl/core/rii_if.sv
// valid/ready channel interfaces for wavelength queries and index results
interface rii_in_if
  import rii_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [WL_W-1:0] wavelength;

  modport source (output valid, output wavelength, input ready);
  modport sink   (input valid, input wavelength, output ready);
endinterface

interface rii_out_if
  import rii_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] index_real;
  logic [OUT_W-1:0] index_imag;

  modport source (output valid, output index_real, output index_imag, input ready);
  modport sink   (input valid, input index_real, input index_imag, output ready);
endinterface

// File: rtl/core/rii_div.sv
// pipelined restoring divider, one quotient bit per stage, two numerators over one divisor
module rii_div
  import rii_pkg::*;
#(
  parameter int QW = FRACTION_BITS_DEF + 3,
  parameter int DW = SEG_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [QW+DW-1:0] num_re,
  input  logic [QW+DW-1:0] num_im,
  input  logic [DW-1:0]    den,
  output logic             out_valid,
  output logic [QW-1:0]    q_re,
  output logic [QW-1:0]    q_im
);

  localparam int NW = QW + DW;

  logic [QW-1:0] v_r;
  logic [DW-1:0] rem_re_r [QW];
  logic [DW-1:0] rem_im_r [QW];
  logic [QW-1:0] wk_re_r  [QW];
  logic [QW-1:0] wk_im_r  [QW];
  logic [DW-1:0] den_r    [QW];

  // shift in the next numerator bit, subtract when it fits; quotient bits fill from the bottom
  function automatic logic [DW+QW-1:0] div_step(logic [DW-1:0] rem, logic [QW-1:0] work,
                                                logic [DW-1:0] d);
    logic [DW:0] sh;
    logic        bit_q;
    sh    = {rem, work[QW-1]};
    bit_q = (sh >= {1'b0, d});
    if (bit_q) sh = sh - {1'b0, d};
    return {sh[DW-1:0], work[QW-2:0], bit_q};
  endfunction

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_valid};
    end
  end

  // stage payload; upper numerator bits start as the partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      {rem_re_r[0], wk_re_r[0]} <= div_step(num_re[NW-1:QW], num_re[QW-1:0], den);
      {rem_im_r[0], wk_im_r[0]} <= div_step(num_im[NW-1:QW], num_im[QW-1:0], den);
      den_r[0] <= den;
      for (int k = 1; k < QW; k++) begin
        {rem_re_r[k], wk_re_r[k]} <= div_step(rem_re_r[k-1], wk_re_r[k-1], den_r[k-1]);
        {rem_im_r[k], wk_im_r[k]} <= div_step(rem_im_r[k-1], wk_im_r[k-1], den_r[k-1]);
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign q_re      = wk_re_r[QW-1];
  assign q_im      = wk_im_r[QW-1];

  // a zero divisor never enters
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (en && in_valid) |-> (den != '0))
    else $error("divider fed a zero divisor");

  // final remainders stay below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[QW-1] |-> ((rem_re_r[QW-1] < den_r[QW-1]) && (rem_im_r[QW-1] < den_r[QW-1])))
    else $error("divider remainder out of range");

endmodule

// File: rtl/core/refraction_index_interpolator_top.sv
// silicon complex refraction index: table segment search, linear interpolation, division
// pipeline from input beat to result:
//   five front stages, one divider stage per quotient bit, one output register
// throughput: one beat per cycle; a stalled result freezes every stage in place
// reset clears only the stage valid bits; the table is constant and needs no clearing
module refraction_index_interpolator_top
  import rii_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  rii_in_if.sink           in_chan,
  rii_out_if.source        out_chan
);

  localparam int N  = used_points(TABLE_ENTRIES);
  localparam int IW = $clog2(N);
  localparam int VW = FRACTION_BITS + 3;
  localparam int NW = VW + SEG_W;

  // constant tables in fixed point
  logic [VW-1:0]   fix_re [N];
  logic [VW-1:0]   fix_im [N];
  logic [WL_W-1:0] wl_tab [N];

  for (genvar g = 0; g < N; g++) begin : g_rom
    assign fix_re[g] = VW'(to_fixed(ROM_RE[g], FRACTION_BITS));
    assign fix_im[g] = VW'(to_fixed(ROM_IM[g], FRACTION_BITS));
    assign wl_tab[g] = ROM_WL[g];
  end

  logic en;

  logic            v1_r, below1_r;
  logic [WL_W-1:0] w1_r;
  logic [N-1:0]    lt1_r, lt_nxt;

  logic            v2_r, below2_r, above2_r;
  logic [WL_W-1:0] w2_r;
  logic [IW-1:0]   seg2_r, seg_nxt, seg_hi;

  logic             v3_r;
  logic [VW-1:0]    a_re_r, b_re_r, a_im_r, b_im_r;
  logic [VW-1:0]    a_re_nxt, b_re_nxt, a_im_nxt, b_im_nxt;
  logic [SEG_W-1:0] d1_r, d2_r, den3_r, d1_nxt, d2_nxt, den_nxt;

  logic             v4_r;
  logic [NW-1:0]    pa_re_r, pb_re_r, pa_im_r, pb_im_r;
  logic [SEG_W-1:0] den4_r;

  logic             v5_r;
  logic [NW-1:0]    num_re_r, num_im_r;
  logic [SEG_W-1:0] den5_r;

  logic             div_v;
  logic [VW-1:0]    q_re, q_im;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_re_r, out_im_r;

  // whole pipe moves unless a result waits untaken
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // stage 1: compare against every table wavelength
  always_comb begin
    for (int j = 0; j < N; j++) lt_nxt[j] = (in_chan.wavelength > wl_tab[j]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r     <= in_chan.wavelength;
      lt1_r    <= lt_nxt;
      below1_r <= (in_chan.wavelength < wl_tab[0]);
    end
  end

  // stage 2: highest point below the query picks the segment, the last point excluded
  always_comb begin
    seg_nxt = '0;
    for (int j = 0; j < N - 1; j++) begin
      if (lt1_r[j]) seg_nxt = IW'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w2_r     <= w1_r;
      seg2_r   <= seg_nxt;
      below2_r <= below1_r;
      above2_r <= lt1_r[N-1];
    end
  end

  // stage 3: fetch segment end points and distances; outside the table use one end, weight one
  assign seg_hi = seg2_r + IW'(1);

  always_comb begin
    if (below2_r) begin
      a_re_nxt = fix_re[0];
      b_re_nxt = fix_re[0];
      a_im_nxt = fix_im[0];
      b_im_nxt = fix_im[0];
      d1_nxt   = '0;
      d2_nxt   = SEG_W'(1);
      den_nxt  = SEG_W'(1);
    end else if (above2_r) begin
      a_re_nxt = fix_re[N-1];
      b_re_nxt = fix_re[N-1];
      a_im_nxt = fix_im[N-1];
      b_im_nxt = fix_im[N-1];
      d1_nxt   = '0;
      d2_nxt   = SEG_W'(1);
      den_nxt  = SEG_W'(1);
    end else begin
      a_re_nxt = fix_re[seg2_r];
      b_re_nxt = fix_re[seg_hi];
      a_im_nxt = fix_im[seg2_r];
      b_im_nxt = fix_im[seg_hi];
      d1_nxt   = SEG_W'(w2_r - wl_tab[seg2_r]);
      d2_nxt   = SEG_W'(wl_tab[seg_hi] - w2_r);
      den_nxt  = SEG_W'(wl_tab[seg_hi] - wl_tab[seg2_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_re_r <= a_re_nxt;
      b_re_r <= b_re_nxt;
      a_im_r <= a_im_nxt;
      b_im_r <= b_im_nxt;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      den3_r <= den_nxt;
    end
  end

  // stage 4: weighted products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_re_r <= NW'(a_re_r) * NW'(d2_r);
      pb_re_r <= NW'(b_re_r) * NW'(d1_r);
      pa_im_r <= NW'(a_im_r) * NW'(d2_r);
      pb_im_r <= NW'(b_im_r) * NW'(d1_r);
      den4_r  <= den3_r;
    end
  end

  // stage 5: numerator sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_re_r <= pa_re_r + pb_re_r;
      num_im_r <= pa_im_r + pb_im_r;
      den5_r   <= den4_r;
    end
  end

  // truncating division by the segment width
  rii_div #(
    .QW (VW),
    .DW (SEG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .num_re    (num_re_r),
    .num_im    (num_im_r),
    .den       (den5_r),
    .out_valid (div_v),
    .q_re      (q_re),
    .q_im      (q_im)
  );

  // clip to the output field
  function automatic logic [OUT_W-1:0] sat_out(logic [VW-1:0] q);
    logic [63:0] qw;
    qw = 64'(q);
    return (qw > OUT_MAX) ? OUT_W'(OUT_MAX) : qw[OUT_W-1:0];
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_re_r <= sat_out(q_re);
      out_im_r <= sat_out(q_im);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.index_real = out_re_r;
  assign out_chan.index_imag = out_im_r;

  // a query is never both below and above the table
  a_range_excl: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> !(below2_r && above2_r))
    else $error("query flagged below and above the table");

  // selected segment lies inside the table
  a_seg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (seg2_r <= IW'(N - 2)))
    else $error("segment index past the table");

  // distances to both ends add up to the segment width
  a_dist_sum: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> ((SEG_W'(d1_r + d2_r) == den3_r) && (den3_r != '0)))
    else $error("segment distances disagree with segment width");

endmodule
